### src/alu32_pkg.sv
`timescale 1ns / 1ps

package alu32_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned SHAMT_W = $clog2(WORD_W);
    localparam int unsigned DIV_STEPS = WORD_W;

    typedef enum logic [3:0] {
        FN_ADD = 4'd0,
        FN_SUB = 4'd1,
        FN_MUL = 4'd2,
        FN_DIVU = 4'd3,
        FN_LSR = 4'd4,
        FN_LSL = 4'd5,
        FN_AND = 4'd6,
        FN_OR = 4'd7,
        FN_XOR = 4'd8,
        FN_ASR = 4'd9,
        FN_NEG = 4'd10,
        FN_NOT = 4'd11
    } alu32_func_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_DIV0 = 2'd1,
        ERR_BADOP = 2'd2
    } alu32_err_t;

    // One slot of the division chain. For every operation but a real divide,
    // quot already holds the final value and the cells pass it through.
    typedef struct packed {
        logic is_div;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quot;
        logic [WORD_W-1:0] divisor;
        alu32_err_t err;
    } alu32_cell_t;

endpackage

### src/alu32_expression_node.sv
// One operand stage followed by a chain of 32 divider cells that every operation
// passes through. Throughput: one operation per cycle while the output is not
// stalled; each cell retires one quotient bit.
// A stalled output only holds the cells that are full; bubbles still close up.
// Reset (rst_n low, asynchronous) empties the chain; no data is kept.
`timescale 1ns / 1ps

module alu32_expression_node (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [3:0]                      func,
    input  logic [alu32_pkg::WORD_W-1:0]    operand_a,
    input  logic [alu32_pkg::WORD_W-1:0]    operand_b,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [alu32_pkg::WORD_W-1:0]    result,
    output logic [1:0]                      error_code
);

    localparam int unsigned N = alu32_pkg::DIV_STEPS;

    logic chain_valid [0:N];
    logic chain_ready [0:N];
    alu32_pkg::alu32_cell_t chain_data [0:N];

    alu32_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        alu32_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    assign chain_ready[N] = out_ready;
    assign out_valid = chain_valid[N];
    assign result = chain_data[N].quot;
    assign error_code = chain_data[N].err;

endmodule

### src/alu32_front.sv
`timescale 1ns / 1ps

module alu32_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [3:0]                          func,
    input  logic [alu32_pkg::WORD_W-1:0]        operand_a,
    input  logic [alu32_pkg::WORD_W-1:0]        operand_b,
    output logic                                out_valid,
    input  logic                                out_ready,
    output alu32_pkg::alu32_cell_t              out_data
);

    logic valid_reg;
    logic valid_next;
    alu32_pkg::alu32_cell_t data_reg;
    alu32_pkg::alu32_cell_t data_next;
    logic big_shift;
    logic [alu32_pkg::SHAMT_W-1:0] shamt;

    assign big_shift = |operand_b[alu32_pkg::WORD_W-1:alu32_pkg::SHAMT_W];
    assign shamt = operand_b[alu32_pkg::SHAMT_W-1:0];

    always_comb
    begin
        data_next.is_div = 1'b0;
        data_next.rem = '0;
        data_next.quot = '1;
        data_next.divisor = operand_b;
        data_next.err = alu32_pkg::ERR_NONE;
        case (alu32_pkg::alu32_func_t'(func))
            alu32_pkg::FN_ADD: data_next.quot = operand_a + operand_b;
            alu32_pkg::FN_SUB: data_next.quot = operand_a - operand_b;
            alu32_pkg::FN_MUL: data_next.quot = operand_a * operand_b;
            alu32_pkg::FN_DIVU:
            begin
                if (operand_b == '0)
                begin
                    data_next.err = alu32_pkg::ERR_DIV0;
                end
                else
                begin
                    data_next.is_div = 1'b1;
                    data_next.quot = operand_a;
                end
            end
            alu32_pkg::FN_LSR: data_next.quot = big_shift ? '0 : (operand_a >> shamt);
            alu32_pkg::FN_LSL: data_next.quot = big_shift ? '0 : (operand_a << shamt);
            alu32_pkg::FN_AND: data_next.quot = operand_a & operand_b;
            alu32_pkg::FN_OR: data_next.quot = operand_a | operand_b;
            alu32_pkg::FN_XOR: data_next.quot = operand_a ^ operand_b;
            alu32_pkg::FN_ASR:
            begin
                if (big_shift)
                begin
                    data_next.quot = {alu32_pkg::WORD_W{operand_a[alu32_pkg::WORD_W-1]}};
                end
                else
                begin
                    data_next.quot = $unsigned($signed(operand_a) >>> shamt);
                end
            end
            alu32_pkg::FN_NEG: data_next.quot = '0 - operand_a;
            alu32_pkg::FN_NOT: data_next.quot = ~operand_a;
            default: data_next.err = alu32_pkg::ERR_BADOP;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

### src/alu32_cell.sv
`timescale 1ns / 1ps

module alu32_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  alu32_pkg::alu32_cell_t  in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output alu32_pkg::alu32_cell_t  out_data
);

    logic valid_reg;
    logic valid_next;
    alu32_pkg::alu32_cell_t data_reg;
    alu32_pkg::alu32_cell_t data_next;
    logic [alu32_pkg::WORD_W:0] partial;
    logic [alu32_pkg::WORD_W:0] trial;

    // One restoring division step: shift in the next dividend bit and
    // subtract the divisor if it fits.
    assign partial = {in_data.rem, in_data.quot[alu32_pkg::WORD_W-1]};
    assign trial = partial - {1'b0, in_data.divisor};

    always_comb
    begin
        data_next = in_data;
        if (in_data.is_div)
        begin
            if (!trial[alu32_pkg::WORD_W])
            begin
                data_next.rem = trial[alu32_pkg::WORD_W-1:0];
                data_next.quot = {in_data.quot[alu32_pkg::WORD_W-2:0], 1'b1};
            end
            else
            begin
                data_next.rem = partial[alu32_pkg::WORD_W-1:0];
                data_next.quot = {in_data.quot[alu32_pkg::WORD_W-2:0], 1'b0};
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

### src/alu32_checker.sv
`timescale 1ns / 1ps

module alu32_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [alu32_pkg::WORD_W-1:0]    result,
    input logic [1:0]                      error_code
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid while in reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result) && $stable(error_code))
        else $error("stalled result changed");

    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output drains");

    a_err_ones: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code != alu32_pkg::ERR_NONE) |-> (result == '1))
        else $error("error result is not all ones");

endmodule

bind alu32_expression_node alu32_checker u_alu32_checker (.*);
